[rtl/accel_average_tilt_angles_unit_assert.svh]
// Assertion macros for the tilt angle unit checker.
// Needs clk and rst in the scope of each use.
`ifndef ACCEL_AVERAGE_TILT_ANGLES_UNIT_ASSERT_SVH
`define ACCEL_AVERAGE_TILT_ANGLES_UNIT_ASSERT_SVH

// same-cycle implication
`define AAT_HOLDS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define AAT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/aat_pkg.sv]
// Shared constants and helper functions for the tilt angle unit.
// No dependencies.
package aat_pkg;

  localparam int LEG_SHIFT    = 14;
  localparam int LEG_W        = 16 + LEG_SHIFT;
  localparam int TAB_FRAC     = 16;
  localparam int CORDIC_STEPS = 17;
  localparam int SQ_STEPS     = 16;
  localparam int ROOT_STEPS   = LEG_W;
  localparam int DIV_STEPS    = 24;
  localparam logic [22:0] NINETY_FULL = 23'(90 << TAB_FRAC);
  localparam logic [2:0]  REG_SAMPLE_COUNT = 3'd0;
  localparam logic [7:0]  SAMPLE_COUNT_RESET = 8'd10;

  function automatic logic [15:0] mag16(input logic signed [15:0] v);
    logic [15:0] r;
    r = v[15] ? 16'(-v) : 16'(v);
    return r;
  endfunction

  function automatic logic [21:0] atan_deg(input logic [4:0] i);
    logic [21:0] r;
    case (i)
      5'd0:    r = 22'd2949120;
      5'd1:    r = 22'd1740967;
      5'd2:    r = 22'd919879;
      5'd3:    r = 22'd466945;
      5'd4:    r = 22'd234379;
      5'd5:    r = 22'd117304;
      5'd6:    r = 22'd58666;
      5'd7:    r = 22'd29335;
      5'd8:    r = 22'd14668;
      5'd9:    r = 22'd7334;
      5'd10:   r = 22'd3667;
      5'd11:   r = 22'd1833;
      5'd12:   r = 22'd917;
      5'd13:   r = 22'd458;
      5'd14:   r = 22'd229;
      5'd15:   r = 22'd115;
      5'd16:   r = 22'd57;
      default: r = 22'd0;
    endcase
    return r;
  endfunction

endpackage

[rtl/aat_div.sv]
// Bit-serial restoring divider: signed 24-bit sum over an 8-bit count.
// Uses aat_pkg.
module aat_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [23:0] dividend,
  input  logic [7:0]         divisor,
  output logic               done,
  output logic signed [15:0] quot
);

  logic        busy;
  logic [4:0]  cnt;
  logic [7:0]  rem;
  logic [23:0] dvd;
  logic        neg;
  logic [8:0]  rem_sh;
  logic        ge;

  assign rem_sh = {rem, dvd[23]};
  assign ge     = rem_sh >= {1'b0, divisor};
  assign quot   = neg ? 16'(-dvd[15:0]) : 16'(dvd[15:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        neg  <= dividend[23];
        dvd  <= dividend[23] ? 24'(-dividend) : 24'(dividend);
      end else if (busy) begin
        rem <= ge ? 8'(rem_sh - {1'b0, divisor}) : rem_sh[7:0];
        dvd <= {dvd[22:0], ge};
        cnt <= cnt + 5'd1;
        if (cnt == 5'(aat_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[rtl/aat_sqsum.sv]
// Serial root leg: floor(sqrt((b*b + c*c) * 2^28)), shift-add squares
// then one root bit per cycle. Uses aat_pkg.
module aat_sqsum (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic signed [15:0]            b,
  input  logic signed [15:0]            c,
  output logic                          done,
  output logic [aat_pkg::LEG_W-1:0]     root
);

  localparam logic [1:0] P_SQB  = 2'd0;
  localparam logic [1:0] P_SQC  = 2'd1;
  localparam logic [1:0] P_ROOT = 2'd2;

  logic        busy;
  logic [1:0]  phase;
  logic [4:0]  cnt;
  logic [31:0] mc;
  logic [15:0] mp;
  logic [15:0] cmag;
  logic [31:0] acc;
  logic [31:0] acc_add;
  logic [31:0] rad;
  logic [31:0] rem;
  logic [33:0] rem_sh;
  logic [33:0] trial;
  logic        ge;

  assign acc_add = acc + (mp[0] ? mc : 32'd0);
  assign rem_sh  = {rem, rad[31:30]};
  assign trial   = {2'b00, root, 2'b01};
  assign ge      = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      phase <= P_SQB;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        phase <= P_SQB;
        cnt   <= '0;
        acc   <= '0;
        mc    <= {16'd0, aat_pkg::mag16(b)};
        mp    <= aat_pkg::mag16(b);
        cmag  <= aat_pkg::mag16(c);
      end else if (busy) begin
        case (phase)
          P_SQB, P_SQC: begin
            acc <= acc_add;
            mc  <= {mc[30:0], 1'b0};
            mp  <= {1'b0, mp[15:1]};
            cnt <= cnt + 5'd1;
            if (cnt == 5'(aat_pkg::SQ_STEPS - 1)) begin
              cnt <= '0;
              if (phase == P_SQB) begin
                phase <= P_SQC;
                mc    <= {16'd0, cmag};
                mp    <= cmag;
              end else begin
                phase <= P_ROOT;
                rad   <= acc_add;
                rem   <= '0;
                root  <= '0;
              end
            end
          end
          P_ROOT: begin
            rad  <= {rad[29:0], 2'b00};
            rem  <= ge ? 32'(rem_sh - trial) : rem_sh[31:0];
            root <= {root[aat_pkg::LEG_W-2:0], ge};
            cnt  <= cnt + 5'd1;
            if (cnt == 5'(aat_pkg::ROOT_STEPS - 1)) begin
              busy <= 1'b0;
              done <= 1'b1;
            end
          end
          default: begin
            busy <= 1'b0;
          end
        endcase
      end
    end
  end

endmodule

[rtl/aat_cordic.sv]
// Vectoring CORDIC, one rotation per cycle, giving |atan(num/den)| in degrees
// rounded to FRAC_BITS fraction bits. Uses aat_pkg.
module aat_cordic #(
  parameter int FRAC_BITS = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [aat_pkg::LEG_W-1:0] den,
  input  logic [aat_pkg::LEG_W-1:0] num,
  output logic                      done,
  output logic [14:0]               mag
);

  localparam int          SH  = aat_pkg::TAB_FRAC - FRAC_BITS;
  localparam logic [23:0] RND = 24'(1) << (SH - 1);

  logic               busy;
  logic [4:0]         step;
  logic signed [33:0] x;
  logic signed [33:0] y;
  logic signed [24:0] z;
  logic               den_zero;
  logic               num_zero;
  logic signed [33:0] dx;
  logic [33:0]        ymag;
  logic [33:0]        dyabs;
  logic signed [33:0] dy;
  logic signed [24:0] t;
  logic               ypos;
  logic [22:0]        zc;
  logic [23:0]        rsh;

  assign dx    = x >>> step;
  assign ymag  = y[33] ? 34'(-y) : 34'(y);
  assign dyabs = ymag >> step;
  assign dy    = y[33] ? 34'(-dyabs) : 34'(dyabs);
  assign t     = {3'b000, aat_pkg::atan_deg(step)};
  assign ypos  = !y[33] && (y != '0);

  always_comb begin
    if (den_zero) begin
      zc = num_zero ? 23'd0 : aat_pkg::NINETY_FULL;
    end else if (z[24]) begin
      zc = 23'd0;
    end else if (z > $signed({2'b00, aat_pkg::NINETY_FULL})) begin
      zc = aat_pkg::NINETY_FULL;
    end else begin
      zc = z[22:0];
    end
    rsh = ({1'b0, zc} + RND) >> SH;
    mag = (rsh > 24'd32767) ? 15'h7fff : rsh[14:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        step     <= '0;
        x        <= {4'b0000, den};
        y        <= {4'b0000, num};
        z        <= '0;
        den_zero <= den == '0;
        num_zero <= num == '0;
      end else if (busy) begin
        if (ypos) begin
          x <= x + dy;
          y <= y - dx;
          z <= z + t;
        end else begin
          x <= x - dy;
          y <= y + dx;
          z <= z - t;
        end
        step <= step + 5'd1;
        if (step == 5'(aat_pkg::CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[rtl/accel_average_tilt_angles_unit.sv]
// Accelerometer averaging and tilt angle unit: top level.
// Uses aat_pkg, aat_div, aat_sqsum and aat_cordic.
//
// Input channel (in_valid/in_stall, accel_x/y/z): one three-axis sample per
// item. Samples that do not close a set are taken one per cycle.
// When the sample count in the set reaches sample_count (zero counts as one)
// the set closes: the block stalls its input while it divides the three sums
// (one quotient bit a cycle), then for each of the three angles squares two
// averages by shift-add, takes the root one bit a cycle and runs a CORDIC of
// 17 rotations. When the output register is free, the squares and roots take
// most of the time from the closing sample to out_valid. in_stall falls in
// the same cycle as out_valid rises.
// Output channel (out_valid/out_stall): averages and tilt angles in degrees
// with ANGLE_FRAC_BITS fraction bits. The result sits in an output register
// held while out_stall is high; new samples are still taken meanwhile, and a
// closing set waits for that register before it is loaded.
// Configuration: APB register sample_count at address 0, reset value 10.
// Reset (rst, synchronous) clears the sums, the sample count in the set and
// any pending result.
module accel_average_tilt_angles_unit #(
  parameter int ANGLE_FRAC_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] avg_x,
  output logic signed [15:0] avg_y,
  output logic signed [15:0] avg_z,
  output logic signed [15:0] tilt_x,
  output logic signed [15:0] tilt_y,
  output logic signed [15:0] tilt_z,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_SQ   = 3'd2;
  localparam logic [2:0] S_COR  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]         state;
  logic [1:0]         axis;
  logic [7:0]         sample_count;
  logic [7:0]         samples_taken;
  logic [7:0]         taken_next;
  logic [7:0]         need;
  logic               in_fire;
  logic               closing;
  logic               out_load;
  logic signed [23:0] sum_x, sum_y, sum_z;
  logic signed [23:0] sum_x_next, sum_y_next, sum_z_next;
  logic signed [23:0] dsum_x, dsum_y, dsum_z;
  logic [7:0]         set_size;
  logic signed [15:0] ax, ay, az, tx, ty, tz;

  logic               div_start, div_done;
  logic signed [23:0] div_dividend;
  logic signed [15:0] div_quot;
  logic               sq_start, sq_done;
  logic signed [15:0] sq_b, sq_c;
  logic [aat_pkg::LEG_W-1:0] root;
  logic               cor_start, cor_done;
  logic [aat_pkg::LEG_W-1:0] cor_den, cor_num;
  logic [14:0]        cor_mag;
  logic               ang_neg;
  logic signed [15:0] ang;

  assign pready     = 1'b1;
  assign prdata     = (paddr == aat_pkg::REG_SAMPLE_COUNT) ? {24'd0, sample_count} : 32'd0;
  assign in_stall   = state != S_IDLE;
  assign in_fire    = in_valid && !in_stall;
  assign taken_next = samples_taken + 8'd1;
  assign need       = (sample_count == 8'd0) ? 8'd1 : sample_count;
  assign closing    = taken_next >= need;
  assign out_load   = (state == S_OUT) && (!out_valid || !out_stall);
  assign sum_x_next = sum_x + {{8{accel_x[15]}}, accel_x};
  assign sum_y_next = sum_y + {{8{accel_y[15]}}, accel_y};
  assign sum_z_next = sum_z + {{8{accel_z[15]}}, accel_z};

  always_comb begin
    case (axis)
      2'd0: begin
        div_dividend = dsum_x;
        sq_b = ay;
        sq_c = az;
        cor_den = root;
        cor_num = {aat_pkg::mag16(ax), aat_pkg::LEG_SHIFT'(0)};
        ang_neg = ax[15];
      end
      2'd1: begin
        div_dividend = dsum_y;
        sq_b = ax;
        sq_c = az;
        cor_den = root;
        cor_num = {aat_pkg::mag16(ay), aat_pkg::LEG_SHIFT'(0)};
        ang_neg = ay[15];
      end
      default: begin
        div_dividend = dsum_z;
        sq_b = ax;
        sq_c = ay;
        cor_den = {aat_pkg::mag16(az), aat_pkg::LEG_SHIFT'(0)};
        cor_num = (az == '0) ? aat_pkg::LEG_W'(1) : root;
        ang_neg = az[15];
      end
    endcase
    ang = ang_neg ? 16'(-{1'b0, cor_mag}) : {1'b0, cor_mag};
  end

  aat_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (set_size),
    .done     (div_done),
    .quot     (div_quot)
  );

  aat_sqsum u_sqsum (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .b     (sq_b),
    .c     (sq_c),
    .done  (sq_done),
    .root  (root)
  );

  aat_cordic #(
    .FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cor_start),
    .den   (cor_den),
    .num   (cor_num),
    .done  (cor_done),
    .mag   (cor_mag)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= aat_pkg::SAMPLE_COUNT_RESET;
    end else if (psel && penable && pwrite && paddr == aat_pkg::REG_SAMPLE_COUNT) begin
      sample_count <= pwdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      axis          <= '0;
      samples_taken <= '0;
      sum_x         <= '0;
      sum_y         <= '0;
      sum_z         <= '0;
      div_start     <= 1'b0;
      sq_start      <= 1'b0;
      cor_start     <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      div_start <= 1'b0;
      sq_start  <= 1'b0;
      cor_start <= 1'b0;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            if (closing) begin
              dsum_x        <= sum_x_next;
              dsum_y        <= sum_y_next;
              dsum_z        <= sum_z_next;
              set_size      <= taken_next;
              sum_x         <= '0;
              sum_y         <= '0;
              sum_z         <= '0;
              samples_taken <= '0;
              axis          <= '0;
              div_start     <= 1'b1;
              state         <= S_DIV;
            end else begin
              sum_x         <= sum_x_next;
              sum_y         <= sum_y_next;
              sum_z         <= sum_z_next;
              samples_taken <= taken_next;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            case (axis)
              2'd0:    ax <= div_quot;
              2'd1:    ay <= div_quot;
              default: az <= div_quot;
            endcase
            if (axis == 2'd2) begin
              axis     <= '0;
              sq_start <= 1'b1;
              state    <= S_SQ;
            end else begin
              axis      <= axis + 2'd1;
              div_start <= 1'b1;
            end
          end
        end
        S_SQ: begin
          if (sq_done) begin
            cor_start <= 1'b1;
            state     <= S_COR;
          end
        end
        S_COR: begin
          if (cor_done) begin
            case (axis)
              2'd0:    tx <= ang;
              2'd1:    ty <= ang;
              default: tz <= ang;
            endcase
            if (axis == 2'd2) begin
              state <= S_OUT;
            end else begin
              axis     <= axis + 2'd1;
              sq_start <= 1'b1;
              state    <= S_SQ;
            end
          end
        end
        S_OUT: begin
          if (out_load) begin
            avg_x  <= ax;
            avg_y  <= ay;
            avg_z  <= az;
            tilt_x <= tx;
            tilt_y <= ty;
            tilt_z <= tz;
            state  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/aat_checker.sv]
// Port-level checker for the tilt angle unit, bound to the top level.
// Uses accel_average_tilt_angles_unit_assert.svh.
`include "accel_average_tilt_angles_unit_assert.svh"

module aat_checker #(
  parameter int ANGLE_FRAC_BITS = 8
) (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] avg_x,
  input logic signed [15:0] avg_z,
  input logic signed [15:0] tilt_x,
  input logic signed [15:0] tilt_z
);

  localparam int LIM = ((90 << ANGLE_FRAC_BITS) > 32767) ? 32767 : (90 << ANGLE_FRAC_BITS);

  `AAT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(tilt_z) && $stable(avg_z), "result changed while stalled")
  `AAT_HOLDS(a_tilt_range, out_valid, tilt_x <= LIM && tilt_x >= -LIM, "tilt_x out of range")
  `AAT_HOLDS(a_load_busy, $rose(out_valid), $past(in_stall), "result appeared without a closed set")
  `AAT_HOLDS(a_sign, out_valid && !avg_z[15] && !avg_x[15], !tilt_z[15] && !tilt_x[15], "angle sign mismatch")

endmodule

bind accel_average_tilt_angles_unit aat_checker #(
  .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
) u_aat_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .avg_x     (avg_x),
  .avg_z     (avg_z),
  .tilt_x    (tilt_x),
  .tilt_z    (tilt_z)
);

[test/testbench.sv]
// Testbench for the accelerometer averaging and tilt angle unit.
// Drives samples and APB writes, predicts each averaged set in place and
// checks every result against that prediction. Depends on aat_pkg and the RTL.
module testbench;

  localparam int AFB = 8;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE = 400;
  localparam logic [2:0] ADDR_UNUSED = 3'd4;
  localparam longint ATAN_TAB [17] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57};

  typedef struct packed {
    logic signed [15:0] ax, ay, az, tx, ty, tz;
  } tilt_set_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] accel_x = '0, accel_y = '0, accel_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] avg_x, avg_y, avg_z, tilt_x, tilt_y, tilt_z;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  accel_average_tilt_angles_unit #(.ANGLE_FRAC_BITS(AFB)) i_dut (.*);

  tilt_set_t expected_sets[$];
  int sum_x, sum_y, sum_z;
  int taken;
  logic [7:0] set_size;
  int errors = 0;
  int samples_sent = 0;
  int sets_seen = 0;
  int quiet = 0;
  int hold = 0;
  int idle_cycles = 0;

  initial forever #6 clk = ~clk;

  function automatic longint unsigned sqrt_floor(longint unsigned v);
    longint unsigned res, bits;
    res = 0;
    bits = 64'd1 << 62;
    while (bits > v) bits >>= 2;
    while (bits != 0) begin
      if (v >= res + bits) begin
        v = v - (res + bits);
        res = (res >> 1) + bits;
      end else begin
        res >>= 1;
      end
      bits >>= 2;
    end
    return res;
  endfunction

  function automatic longint angle_mag(longint unsigned den, longint unsigned num);
    longint x, y, z, p, dx, dy, r;
    x = longint'(den);
    y = longint'(num);
    z = 0;
    if (den == 0) begin
      z = (num == 0) ? 0 : (longint'(90) << 16);
    end else begin
      for (int i = 0; i < 17; i++) begin
        p = longint'(1) << i;
        dx = x / p;
        dy = y / p;
        if (y > 0) begin
          x += dy; y -= dx; z += ATAN_TAB[i];
        end else begin
          x -= dy; y += dx; z -= ATAN_TAB[i];
        end
      end
      if (z < 0) z = 0;
      if (z > (longint'(90) << 16)) z = longint'(90) << 16;
    end
    r = (z + (longint'(1) << (16 - AFB - 1))) >>> (16 - AFB);
    if (r > 32767) r = 32767;
    return r;
  endfunction

  function automatic longint unsigned absl(longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  function automatic longint side_tilt(longint a, longint b, longint c);
    longint unsigned den;
    longint m;
    den = sqrt_floor(longint'(b * b + c * c) << 28);
    m = angle_mag(den, absl(a) << 14);
    return a < 0 ? -m : m;
  endfunction

  task automatic accumulate_sample(input logic signed [15:0] x, y, z);
    int need, n;
    longint ax, ay, az, m;
    tilt_set_t s;
    sum_x += x;
    sum_y += y;
    sum_z += z;
    taken = (taken + 1) & 8'hff;
    need = (set_size == 0) ? 1 : set_size;
    if (taken != 0 && taken < need) return;
    n = (taken == 0) ? 256 : taken;
    ax = sum_x / n;
    ay = sum_y / n;
    az = sum_z / n;
    s.ax = ax[15:0];
    s.ay = ay[15:0];
    s.az = az[15:0];
    m = side_tilt(ax, ay, az);
    s.tx = m[15:0];
    m = side_tilt(ay, ax, az);
    s.ty = m[15:0];
    if (az == 0) begin
      m = angle_mag(0, 1);
    end else begin
      m = angle_mag(absl(az) << 14, sqrt_floor(longint'(ax * ax + ay * ay) << 28));
      if (az < 0) m = -m;
    end
    s.tz = m[15:0];
    expected_sets.push_back(s);
    sum_x = 0;
    sum_y = 0;
    sum_z = 0;
    taken = 0;
  endtask

  task automatic send_sample(input logic signed [15:0] x, y, z);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    accel_x <= x;
    accel_y <= y;
    accel_z <= z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    accumulate_sample(x, y, z);
    samples_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_sets.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    settle();
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == aat_pkg::REG_SAMPLE_COUNT) set_size = data[7:0];
  endtask

  function automatic logic signed [15:0] rand_axis();
    case ($urandom_range(0, 5))
      0:       return 16'sd0;
      1:       return 16'($signed($urandom_range(0, 64)) - 32);
      2:       return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_default_size();
    for (int i = 0; i < 10; i++) send_sample(16'sh7fff, 16'sh8000, 16'sd0);
  endtask

  task automatic test_axis_extremes();
    apb_write(aat_pkg::REG_SAMPLE_COUNT, 32'd1);
    send_sample(16'sd0, 16'sd0, 16'sd0);
    send_sample(16'sd0, 16'sd0, 16'sd5);
    send_sample(16'sd5, 16'sd0, 16'sd0);
    send_sample(-16'sd5, 16'sd0, 16'sd0);
    send_sample(16'sd0, -16'sd7, 16'sd0);
    send_sample(16'sh8000, 16'sh8000, 16'sh8000);
    send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_sample(16'sd0, 16'sd0, -16'sd1);
  endtask

  task automatic test_zero_size();
    apb_write(aat_pkg::REG_SAMPLE_COUNT, 32'd0);
    send_sample(16'sd100, -16'sd200, 16'sd300);
    send_sample(-16'sd1, 16'sd1, -16'sd1);
  endtask

  task automatic test_lowered_size();
    apb_write(aat_pkg::REG_SAMPLE_COUNT, 32'd10);
    for (int i = 0; i < 4; i++) send_sample(16'sd1000, -16'sd3, 16'sd77);
    apb_write(aat_pkg::REG_SAMPLE_COUNT, 32'd2);
    send_sample(16'sd9, 16'sd9, 16'sd9);
  endtask

  task automatic test_unknown_register();
    apb_write(ADDR_UNUSED, 32'hffff_ffff);
    send_sample(16'sd11, 16'sd22, 16'sd33);
    send_sample(16'sd44, 16'sd55, 16'sd66);
  endtask

  task automatic test_random();
    int sz, sets;
    while (samples_sent < 1600) begin
      case ($urandom_range(0, 19))
        0:       sz = 255;
        1:       sz = 0;
        default: sz = $urandom_range(1, 12);
      endcase
      apb_write(aat_pkg::REG_SAMPLE_COUNT, 32'(sz));
      quiet = ($urandom_range(0, 3) == 0);
      sets = (sz > 12) ? 1 : $urandom_range(1, 6);
      for (int i = 0; i < sets * ((sz == 0) ? 1 : sz); i++)
        send_sample(rand_axis(), rand_axis(), rand_axis());
      for (int i = $urandom_range(0, 3); i > 0; i--)
        send_sample(rand_axis(), rand_axis(), rand_axis());
      quiet = 0;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold = $urandom_range(0, 19);
    end else begin
      if (out_valid && !out_stall) hold = quiet ? 0 : $urandom_range(0, 19);
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    tilt_set_t e;
    if (!rst && out_valid && !out_stall) begin
      sets_seen++;
      if (expected_sets.size() == 0) begin
        $error("result with no averaged set pending");
        errors++;
      end else begin
        e = expected_sets.pop_front();
        if (avg_x !== e.ax) begin $error("avg_x exp %0d got %0d", e.ax, avg_x); errors++; end
        if (avg_y !== e.ay) begin $error("avg_y exp %0d got %0d", e.ay, avg_y); errors++; end
        if (avg_z !== e.az) begin $error("avg_z exp %0d got %0d", e.az, avg_z); errors++; end
        if (tilt_x !== e.tx) begin $error("tilt_x exp %0d got %0d", e.tx, tilt_x); errors++; end
        if (tilt_y !== e.ty) begin $error("tilt_y exp %0d got %0d", e.ty, tilt_y); errors++; end
        if (tilt_z !== e.tz) begin $error("tilt_z exp %0d got %0d", e.tz, tilt_z); errors++; end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    sum_x = 0;
    sum_y = 0;
    sum_z = 0;
    taken = 0;
    set_size = aat_pkg::SAMPLE_COUNT_RESET;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_size();
    test_axis_extremes();
    test_zero_size();
    test_lowered_size();
    test_unknown_register();
    test_random();
    settle();
    $display("covered %0d samples and %0d averaged sets over set sizes 0 to 255",
             samples_sent, sets_seen);
    if (errors == 0 && expected_sets.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end
endmodule

[accel_average_tilt_angles_unit.f]
+incdir+rtl
rtl/aat_pkg.sv
rtl/aat_div.sv
rtl/aat_sqsum.sv
rtl/aat_cordic.sv
rtl/accel_average_tilt_angles_unit.sv
rtl/aat_checker.sv
test/testbench.sv
